@@ src/gfli_pkg.sv @@
// Shared types and constants for the linear-interpolation gap filler.
package gfli_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int SERIES_MAX_DEF  = 64;

  // time_index field width; positions never exceed 63
  localparam int IDX_BITS = 6;
  // gap length reaches 63 and run count reaches 64
  localparam int GAP_BITS = IDX_BITS + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FLAT,
    ST_INTERP
  } state_t;

endpackage

@@ src/gfli_in_if.sv @@
// Sample channel: valid/ready with sample, missing flag and end flag.
interface gfli_in_if #(
  parameter int SAMPLE_BITS = gfli_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          is_missing;
  logic                          end_of_series;

  modport source (output valid, output sample, output is_missing, output end_of_series,
                  input ready);
  modport sink   (input valid, input sample, input is_missing, input end_of_series,
                  output ready);
endinterface

@@ src/gfli_out_if.sv @@
// Result channel: valid/ready with corrected value, position and last flag.
interface gfli_out_if #(
  parameter int SAMPLE_BITS = gfli_pkg::SAMPLE_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [SAMPLE_BITS-1:0]     value;
  logic [gfli_pkg::IDX_BITS-1:0]     time_index;
  logic                              run_last;

  modport source (output valid, output value, output time_index, output run_last,
                  input ready);
  modport sink   (input valid, input value, input time_index, input run_last,
                  output ready);
endinterface

@@ src/gfli_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module gfli_div #(
  parameter int NUM_W = gfli_pkg::SAMPLE_BITS_DEF + 1,
  parameter int DEN_W = gfli_pkg::GAP_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // numerator shifts out the top while quotient bits enter the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], ge};
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

endmodule

@@ src/gap_fill_linear_interp.sv @@
// Top level: gap filler that repairs missing samples by linear interpolation.
// A valid sample after no gap passes the flat state and then the output register.
// A sample that closes a gap of g runs through the serial divider, then gives g+1 results.
// Throughput: one result per cycle while draining, unless the output stalls; no new sample is
// taken until a run is sent. The serial divider sets the cost of each gap.
// Reset (rst, synchronous): series state, sequencer and output register clear; idle at once.
module gap_fill_linear_interp #(
  parameter int SAMPLE_BITS = gfli_pkg::SAMPLE_BITS_DEF,
  parameter int SERIES_MAX  = gfli_pkg::SERIES_MAX_DEF
) (
  input logic       clk,
  input logic       rst,
  gfli_in_if.sink   raw,
  gfli_out_if.source cleaned
);

  localparam int ACC_W = SAMPLE_BITS + 1;       // difference of two samples
  localparam int IW    = gfli_pkg::IDX_BITS;
  localparam int GW    = gfli_pkg::GAP_BITS;
  localparam logic [IW-1:0] LAST_POS = IW'(SERIES_MAX - 1);

  // ---------------------------------------------------------------------------
  // Series state: last valid value, whether one was seen, current missing run,
  // position of the next sample.
  // ---------------------------------------------------------------------------
  gfli_pkg::state_t state, state_next;

  logic signed [SAMPLE_BITS-1:0] last_valid;
  logic                          seen_valid;
  logic [GW-1:0]                 gap_length;
  logic [IW-1:0]                 position;

  // Working registers of the request being drained.
  logic signed [SAMPLE_BITS-1:0] hold_val;   // flat value, or closing sample
  logic signed [SAMPLE_BITS-1:0] base;       // previous valid value
  logic [GW-1:0]                 left;       // results still to send
  logic [IW-1:0]                 idx;        // time index of next result
  logic [GW-1:0]                 den;        // gap + 1
  logic                          diff_neg;
  logic signed [ACC_W-1:0]       step_q;     // signed quotient per step
  logic [GW-1:0]                 step_r;     // remainder per step
  logic signed [ACC_W-1:0]       acc;        // trunc(k*diff/den) for current k
  logic [GW-1:0]                 acc_r;      // matching remainder

  // Output register.
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_value;
  logic [IW-1:0]                 out_index;
  logic                          out_last;

  // Divider link.
  logic             div_start;
  logic             div_done;
  logic [ACC_W-1:0] div_quo;
  logic [GW-1:0]    div_rem;

  logic                          accept;
  logic                          end_eff;
  logic signed [ACC_W-1:0]       diff;
  logic [ACC_W-1:0]              diff_mag;
  logic                          slot_free;
  logic                          emit;
  logic                          final_one;
  logic signed [ACC_W-1:0]       interp_sum;
  logic signed [SAMPLE_BITS-1:0] emit_val;
  logic [GW-1:0]                 sum_r;
  logic                          wrap;
  logic signed [ACC_W-1:0]       wrap_step;
  logic signed [ACC_W-1:0]       acc_next;

  assign raw.ready = (state == gfli_pkg::ST_IDLE);
  assign accept    = raw.valid && raw.ready;

  // Forced end at the last slot of a series.
  assign end_eff = raw.end_of_series || (position == LAST_POS);

  assign diff     = ACC_W'(raw.sample) - ACC_W'(last_valid);
  assign diff_mag = diff[ACC_W-1] ? ACC_W'(-diff) : ACC_W'(diff);

  assign slot_free = !out_valid || cleaned.ready;
  assign final_one = (left == GW'(1));

  // Fill value: prev + trunc(k*diff/den); the last result of a run is the sample itself.
  assign interp_sum = ACC_W'(base) + acc;
  assign emit_val   = (state == gfli_pkg::ST_INTERP && !final_one)
                      ? SAMPLE_BITS'(interp_sum) : hold_val;

  // Step k -> k+1: add quotient, carry one more unit when the remainders overflow den.
  assign sum_r     = acc_r + step_r;
  assign wrap      = sum_r >= den;
  assign wrap_step = wrap ? (diff_neg ? -ACC_W'(1) : ACC_W'(1)) : '0;
  assign acc_next  = acc + step_q + wrap_step;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      gfli_pkg::ST_IDLE: begin
        if (accept) begin
          if (raw.is_missing) begin
            if (end_eff) state_next = gfli_pkg::ST_FLAT;
          end else if (gap_length != '0 && seen_valid) begin
            div_start  = 1'b1;
            state_next = gfli_pkg::ST_DIV;
          end else begin
            state_next = gfli_pkg::ST_FLAT;
          end
        end
      end
      gfli_pkg::ST_DIV: begin
        if (div_done) state_next = gfli_pkg::ST_INTERP;
      end
      gfli_pkg::ST_FLAT, gfli_pkg::ST_INTERP: begin
        if (slot_free) begin
          emit = 1'b1;
          if (final_one) state_next = gfli_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gfli_pkg::ST_IDLE;
      last_valid <= '0;
      seen_valid <= 1'b0;
      gap_length <= '0;
      position   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (end_eff) begin
          last_valid <= '0;
          seen_valid <= 1'b0;
          gap_length <= '0;
          position   <= '0;
        end else if (raw.is_missing) begin
          gap_length <= gap_length + GW'(1);
          position   <= position + IW'(1);
        end else begin
          last_valid <= raw.sample;
          seen_valid <= 1'b1;
          gap_length <= '0;
          position   <= position + IW'(1);
        end
      end
      if (emit)               out_valid <= 1'b1;
      else if (cleaned.ready) out_valid <= 1'b0;
    end
  end

  // Working and output payload; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      // Every result run starts at position - gap and counts gap + 1.
      hold_val <= raw.is_missing ? (seen_valid ? last_valid : '0) : raw.sample;
      left     <= gap_length + GW'(1);
      idx      <= position - gap_length[IW-1:0];
      base     <= last_valid;
      den      <= gap_length + GW'(1);
      diff_neg <= diff[ACC_W-1];
    end
    if (div_done) begin
      step_q <= diff_neg ? -$signed(div_quo) : $signed(div_quo);
      acc    <= diff_neg ? -$signed(div_quo) : $signed(div_quo);
      step_r <= div_rem;
      acc_r  <= div_rem;
    end
    if (emit) begin
      left      <= left - GW'(1);
      idx       <= idx + IW'(1);
      out_value <= emit_val;
      out_index <= idx;
      out_last  <= final_one;
      if (state == gfli_pkg::ST_INTERP) begin
        acc   <= acc_next;
        acc_r <= wrap ? GW'(sum_r - den) : sum_r;
      end
    end
  end

  assign cleaned.valid      = out_valid;
  assign cleaned.value      = out_value;
  assign cleaned.time_index = out_index;
  assign cleaned.run_last   = out_last;

  function automatic logic [GW-1:0] den_length_for_div(input logic [GW-1:0] g);
    den_length_for_div = g + GW'(1);
  endfunction

  // |diff| / (gap + 1), once per gap
  gfli_div #(
    .NUM_W (ACC_W),
    .DEN_W (GW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (diff_mag),
    .den   (den_length_for_div(gap_length)),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_valid_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && !raw.is_missing |=> state != gfli_pkg::ST_IDLE)
    else $error("valid sample produced no result run");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == gfli_pkg::ST_DIV)
    else $error("divider finished outside the divide step");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    emit |-> left != '0)
    else $error("result sent with empty run count");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    emit && state == gfli_pkg::ST_INTERP && !final_one |->
      (diff_neg && emit_val <= base && emit_val >= hold_val) ||
      (!diff_neg && emit_val >= base && emit_val <= hold_val))
    else $error("interpolated value outside its end points");

  a_position_step: assert property (@(posedge clk) disable iff (rst)
    accept && !end_eff |=> position == $past(position) + IW'(1))
    else $error("position did not advance");

endmodule
